[rtl/core/mkd_pkg.sv]
// Morse key decoder: shared types, constants and the letter code table.
// Used by mkd_code_table, morse_key_decoder_unit and the testbench; depends on nothing.
`default_nettype none

package mkd_pkg;

  // Code buffer and tick counter sizing
  localparam int MAX_SYMBOLS = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int SLOT_W      = $clog2(MAX_SYMBOLS);
  localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // Field widths of the register set and the result word
  localparam int MS_W     = 16;
  localparam int DEB_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int LETTER_W = 7;
  localparam int OUT_LEN_W  = 3;
  localparam int OUT_BITS_W = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INACTIVITY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd3;

  // Register values after reset
  localparam logic [MS_W-1:0]  DOT_LIMIT_RST  = 16'd250;
  localparam logic [MS_W-1:0]  LETTER_GAP_RST = 16'd1000;
  localparam logic [MS_W-1:0]  INACTIVITY_RST = 16'd5000;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 10'd50;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    EV_SYMBOL   = 2'd0,
    EV_LETTER   = 2'd1,
    EV_INVALID  = 2'd2,
    EV_INACTIVE = 2'd3
  } event_kind_e;

  // Letters A..Z: symbol count and symbol bits (bit i is symbol i, 1 dash)
  localparam int NUM_LETTERS = 26;
  localparam logic [LETTER_W-1:0] ASCII_A = 7'h41;

  typedef logic [2:0] len_tab_t [NUM_LETTERS];
  typedef logic [3:0] bits_tab_t [NUM_LETTERS];

  localparam len_tab_t LETTER_LEN = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam bits_tab_t LETTER_BITS = '{
    4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
    4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
  };

  // Saturating tick counter increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

[rtl/core/mkd_code_table.sv]
// Morse key decoder: letter lookup of a buffered code.
// Depends on mkd_pkg for the letter code table.
`default_nettype none

module mkd_code_table
  import mkd_pkg::*;
(
  input  wire logic [LEN_W-1:0]       code_len_i,
  input  wire logic [MAX_SYMBOLS-1:0] code_bits_i,
  output logic      [LETTER_W-1:0]    letter_o    // 0 when no letter matches
);

  // Codes are unique, so at most one entry matches; OR the hits together
  always_comb begin
    letter_o = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (LEN_W'(LETTER_LEN[i]) == code_len_i &&
          MAX_SYMBOLS'(LETTER_BITS[i]) == code_bits_i) begin
        letter_o = letter_o | (ASCII_A + LETTER_W'(i));
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/morse_key_decoder_unit.sv]
// Morse key decoder top level: input word register, per-tick decode step,
// result register. Depends on mkd_pkg and mkd_code_table.
//
// Usage:
//   Slave stream carries one word per millisecond tick: s_tdata_i[0] is the
//   sampled key level (1 pressed). Master stream carries at most one event
//   per input word: m_tuser_o is the event kind (symbol, letter, invalid
//   code, inactivity), m_tdata_o holds symbol, letter and the code buffer.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while the block is idle; the block does not enforce this.
// Timing:
//   A word is taken into the input register, runs through the decode step
//   and its event, if any, is loaded into the result register that drives
//   m_tvalid_o; a result waiting for m_tready_i holds the step back. One
//   word per cycle sustained while the result register is not stalled.
// Reset:
//   Asynchronous, active low; registers return to their default values,
//   the code buffer and all counters clear, both streams go empty.
// Stall:
//   While a result waits for m_tready_i, one further word is still taken
//   into the input register; the step then waits and s_tready_o drops.
`default_nettype none

module morse_key_decoder_unit
  import mkd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // Configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [MS_W-1:0]      cfg_data_i,

  // Slave stream
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire logic [7:0]           s_tdata_i,   // [0] key_level, [7:1] zero

  // Master stream
  output logic                      m_tvalid_o,
  input  wire logic                 m_tready_i,
  output logic      [15:0]          m_tdata_o,   // [0] symbol, [7:1] letter,
                                                 // [10:8] code_length, [15:11] code_bits
  output logic      [1:0]           m_tuser_o    // [1:0] event_kind
);

  // ---------------------------------------------------------------
  // Configuration registers
  logic [MS_W-1:0]  dot_limit_q, letter_gap_q, inactivity_q;
  logic [DEB_W-1:0] debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_limit_q  <= DOT_LIMIT_RST;
      letter_gap_q <= LETTER_GAP_RST;
      inactivity_q <= INACTIVITY_RST;
      debounce_q   <= DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DOT_LIMIT:  dot_limit_q  <= cfg_data_i;
        REG_LETTER_GAP: letter_gap_q <= cfg_data_i;
        REG_INACTIVITY: inactivity_q <= cfg_data_i;
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: input register feeds the step, step feeds result register
  logic in_valid_q, level_q;
  logic out_valid_q;
  logic step_fire, s_accept;

  assign step_fire  = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || step_fire;
  assign s_accept   = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      level_q <= s_tdata_i[0];
    end
  end

  // ---------------------------------------------------------------
  // Decoder state
  logic                   key_down_q, key_down_d;
  logic [COUNT_WIDTH-1:0] press_q, press_d;
  logic [COUNT_WIDTH-1:0] idle_q, idle_d;
  logic [DEB_W-1:0]       hold_q, hold_d;
  logic [MAX_SYMBOLS-1:0] pattern_q, pattern_d;
  logic [LEN_W-1:0]       plen_q, plen_d;

  // Step outputs
  logic                   emit;
  event_kind_e            kind;
  logic                   sym;
  logic [LETTER_W-1:0]    letter, lut_letter;
  logic [LEN_W-1:0]       ev_len;
  logic [MAX_SYMBOLS-1:0] ev_bits;

  // Working values
  logic [COUNT_WIDTH-1:0] idle_inc;
  logic [SLOT_W-1:0]      slot;

  mkd_code_table u_code_table (
    .code_len_i  (plen_q),
    .code_bits_i (pattern_q),
    .letter_o    (lut_letter)
  );

  assign idle_inc = sat_inc(idle_q);

  // One tick of the decoder
  always_comb begin
    key_down_d = key_down_q;
    press_d    = press_q;
    idle_d     = idle_q;
    hold_d     = hold_q;
    pattern_d  = pattern_q;
    plen_d     = plen_q;
    emit       = 1'b0;
    kind       = EV_SYMBOL;
    sym        = 1'b0;
    letter     = '0;
    ev_len     = plen_q;
    ev_bits    = pattern_q;
    slot       = SLOT_W'(MAX_SYMBOLS - 1);

    priority if (key_down_q) begin
      if (level_q) begin
        press_d = sat_inc(press_q);
      end else begin
        // Release: record dot or dash, start the debounce hold
        sym = (CMP_W'(press_q) < CMP_W'(dot_limit_q)) ? 1'b0 : 1'b1;
        if (plen_q < LEN_W'(MAX_SYMBOLS)) begin
          slot   = plen_q[SLOT_W-1:0];
          plen_d = plen_q + LEN_W'(1);
        end
        pattern_d[slot] = sym;
        key_down_d = 1'b0;
        press_d    = '0;
        idle_d     = '0;
        hold_d     = debounce_q;
        emit       = 1'b1;
        kind       = EV_SYMBOL;
        ev_len     = plen_d;
        ev_bits    = pattern_d;
      end
    end else if (hold_q != '0) begin
      hold_d = hold_q - DEB_W'(1);
      idle_d = idle_inc;
    end else if (level_q) begin
      key_down_d = 1'b1;
      press_d    = COUNT_WIDTH'(1);
    end else begin
      idle_d = idle_inc;
      if (CMP_W'(idle_inc) > CMP_W'(letter_gap_q) && plen_q != '0) begin
        // Letter gap passed with code pending
        emit      = 1'b1;
        letter    = lut_letter;
        kind      = (lut_letter != '0) ? EV_LETTER : EV_INVALID;
        if (lut_letter != '0) begin
          idle_d = '0;
        end
        pattern_d = '0;
        plen_d    = '0;
      end else if (CMP_W'(idle_inc) > CMP_W'(inactivity_q)) begin
        emit      = 1'b1;
        kind      = EV_INACTIVE;
        pattern_d = '0;
        plen_d    = '0;
        idle_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q <= 1'b0;
      press_q    <= '0;
      idle_q     <= '0;
      hold_q     <= '0;
      pattern_q  <= '0;
      plen_q     <= '0;
    end else if (step_fire) begin
      key_down_q <= key_down_d;
      press_q    <= press_d;
      idle_q     <= idle_d;
      hold_q     <= hold_d;
      pattern_q  <= pattern_d;
      plen_q     <= plen_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  event_kind_e            out_kind_q;
  logic                   out_sym_q;
  logic [LETTER_W-1:0]    out_letter_q;
  logic [LEN_W-1:0]       out_len_q;
  logic [MAX_SYMBOLS-1:0] out_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= emit;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      out_kind_q   <= kind;
      out_sym_q    <= sym;
      out_letter_q <= letter;
      out_len_q    <= ev_len;
      out_bits_q   <= ev_bits;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tdata_o  = {OUT_BITS_W'(out_bits_q), OUT_LEN_W'(out_len_q), out_letter_q, out_sym_q};

  // ---------------------------------------------------------------
  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= LEN_W'(MAX_SYMBOLS))
    else $error("code length above buffer size");

  a_hold_key_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != '0) |-> !key_down_q)
    else $error("debounce hold while key is down");

  a_pattern_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pattern_q >> plen_q) == '0)
    else $error("code bits set beyond code length");

  a_letter_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && out_kind_q == EV_LETTER) |-> (out_letter_q >= ASCII_A))
    else $error("letter event without a letter");

  a_no_step_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |-> !step_fire)
    else $error("decode step overran a pending result");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for morse_key_decoder_unit: key ticks in on the slave stream, events
// out on the master stream, each event compared with a tick-by-tick decoder model kept here.
// Depends on mkd_pkg and the decoder RTL only.

module testbench;
  import mkd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One decoder event as carried by m_tuser_o / m_tdata_o
  typedef struct packed {
    event_kind_e           kind;
    logic                  sym;
    logic [LETTER_W-1:0]   letter;
    logic [OUT_LEN_W-1:0]  len;
    logic [OUT_BITS_W-1:0] bits;
  } key_event_t;

  // Directed script: register write, run of one key level, or a train of presses
  typedef enum logic [1:0] {ROW_CFG, ROW_LEVEL, ROW_PULSES} row_op_e;

  // arg: register index, key level, or press width; count: value, ticks, or presses.
  // Where typed is set, the last word of the row expects fires/ev instead of the model.
  typedef struct packed {
    row_op_e    op;
    int         arg;
    int         count;
    logic       typed;
    logic       fires;
    key_event_t ev;
  } script_row_t;

  localparam int NUM_ROWS = 34;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_WORDS = 200;

  // Idling per random phase: none, sender gaps, receiver stalls, both
  localparam int GAP_PCT   [4] = '{0, 74, 0, 19};
  localparam int STALL_PCT [4] = '{0, 0, 74, 19};

  localparam key_event_t NO_EV = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [MS_W-1:0]      cfg_data_i = '0;
  logic                 s_tvalid_i = 1'b0;
  logic                 s_tready_o;
  logic [7:0]           s_tdata_i = '0;    // [0] key_level, [7:1] zero
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  logic [15:0]          m_tdata_o;         // [0] symbol, [7:1] letter, [10:8] code_length,
                                           // [15:11] code_bits
  logic [1:0]           m_tuser_o;         // [1:0] event_kind

  morse_key_decoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Letters A..Z as dot/dash strings, symbol 0 first
  string morse_table [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-", ".-..",
    "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
    "-.--", "--.."
  };

  // Decoder model: registers and state
  logic [MS_W-1:0]        cfg_dot = DOT_LIMIT_RST;
  logic [MS_W-1:0]        cfg_gap = LETTER_GAP_RST;
  logic [MS_W-1:0]        cfg_inact = INACTIVITY_RST;
  logic [DEB_W-1:0]       cfg_deb = DEBOUNCE_RST;
  logic                   key_held = 1'b0;
  logic [COUNT_WIDTH-1:0] press_cnt = '0;
  logic [COUNT_WIDTH-1:0] idle_cnt = '0;
  logic [DEB_W-1:0]       hold_cnt = '0;
  logic [MAX_SYMBOLS-1:0] code_pat = '0;
  logic [OUT_LEN_W-1:0]   code_len = '0;

  key_event_t pending_events [$];
  int         mismatches = 0;
  int         words_sent = 0;
  int         sender_gap_pct = 0;
  int         stall_pct = 0;

  script_row_t script_rows [NUM_ROWS] = '{
    // reset values: a one-tick press is a dot, decoded once the debounce hold runs out
    '{ROW_LEVEL, 1, 1, 1'b1, 1'b0, NO_EV},
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_SYMBOL, 1'b0, 7'h00, 3'd1, 5'h00}},
    '{ROW_CFG, REG_LETTER_GAP, 4, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 0, 51, 1'b1, 1'b1, '{EV_LETTER, 1'b0, 7'h45, 3'd1, 5'h00}},   // E
    // short timing
    '{ROW_CFG, REG_DOT_LIMIT, 3, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_LETTER_GAP, 4, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_INACTIVITY, 9, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_DEBOUNCE, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 1, 3, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_SYMBOL, 1'b1, 7'h00, 3'd1, 5'h01}},
    '{ROW_PULSES, 2, 1, 1'b1, 1'b1, '{EV_SYMBOL, 1'b0, 7'h00, 3'd2, 5'h01}},
    '{ROW_LEVEL, 0, 5, 1'b1, 1'b1, '{EV_LETTER, 1'b0, 7'h4E, 3'd2, 5'h01}},    // N
    '{ROW_LEVEL, 0, 10, 1'b1, 1'b1, '{EV_INACTIVE, 1'b0, 7'h00, 3'd0, 5'h00}},
    // six dots: the last one overwrites the top slot, five symbols never decode
    '{ROW_PULSES, 1, 6, 1'b1, 1'b1, '{EV_SYMBOL, 1'b0, 7'h00, 3'd5, 5'h00}},
    '{ROW_LEVEL, 0, 5, 1'b1, 1'b1, '{EV_INVALID, 1'b0, 7'h00, 3'd5, 5'h00}},
    // idle time keeps running after an invalid code
    '{ROW_LEVEL, 0, 5, 1'b1, 1'b1, '{EV_INACTIVE, 1'b0, 7'h00, 3'd0, 5'h00}},
    '{ROW_PULSES, 3, 4, 1'b1, 1'b1, '{EV_SYMBOL, 1'b1, 7'h00, 3'd4, 5'h0F}},
    '{ROW_LEVEL, 0, 5, 1'b1, 1'b1, '{EV_INVALID, 1'b0, 7'h00, 3'd4, 5'h0F}},
    // lowest settings: every press a dash, decode on the first idle tick
    '{ROW_CFG, REG_DOT_LIMIT, 1, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_LETTER_GAP, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_INACTIVITY, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_DEBOUNCE, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_PULSES, 1, 1, 1'b1, 1'b1, '{EV_SYMBOL, 1'b1, 7'h00, 3'd1, 5'h01}},
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_LETTER, 1'b0, 7'h54, 3'd1, 5'h01}},    // T
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_INACTIVE, 1'b0, 7'h00, 3'd0, 5'h00}},
    // highest limits: a long press is still a dot, nothing decodes until the gap drops
    '{ROW_CFG, REG_DOT_LIMIT, 65535, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_LETTER_GAP, 65535, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_INACTIVITY, 65535, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_DEBOUNCE, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 1, 20, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_SYMBOL, 1'b0, 7'h00, 3'd1, 5'h00}},
    '{ROW_LEVEL, 0, 20, 1'b0, 1'b0, NO_EV},
    '{ROW_CFG, REG_LETTER_GAP, 0, 1'b0, 1'b0, NO_EV},
    '{ROW_LEVEL, 0, 1, 1'b1, 1'b1, '{EV_LETTER, 1'b0, 7'h45, 3'd1, 5'h00}}     // E
  };

  // Clock, 4 ns period
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver readiness, redrawn every cycle
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // ASCII letter for a code, zero when the code is not a letter
  function automatic logic [LETTER_W-1:0] letter_of(input logic [OUT_LEN_W-1:0] n,
                                                    input logic [MAX_SYMBOLS-1:0] pat);
    logic hit;
    for (int i = 0; i < 26; i++) begin
      hit = (morse_table[i].len() == n) && ((pat >> n) == 0);
      for (int k = 0; k < morse_table[i].len(); k++) begin
        if ((morse_table[i][k] == "-") != pat[k]) hit = 1'b0;
      end
      if (hit) return ASCII_A + LETTER_W'(i);
    end
    return '0;
  endfunction

  // One key tick through the decoder model
  task automatic decode_tick(input logic lvl, output logic fired, output key_event_t ev);
    logic [LETTER_W-1:0] ch;
    int                  slot;
    fired = 1'b0;
    ev = '0;
    if (key_held) begin
      if (lvl) begin
        press_cnt = bump(press_cnt);
      end else begin
        ev.sym = (press_cnt >= cfg_dot);
        if (code_len < MAX_SYMBOLS) begin
          slot = code_len;
          code_len++;
        end else begin
          slot = MAX_SYMBOLS - 1;
        end
        code_pat[slot] = ev.sym;
        key_held = 1'b0;
        press_cnt = '0;
        idle_cnt = '0;
        hold_cnt = cfg_deb;
        ev.kind = EV_SYMBOL;
        ev.len = code_len;
        ev.bits = code_pat;
        fired = 1'b1;
      end
    end else if (hold_cnt != 0) begin
      // debounce: key and timeouts ignored, idle time still runs
      hold_cnt--;
      idle_cnt = bump(idle_cnt);
    end else if (lvl) begin
      key_held = 1'b1;
      press_cnt = 1;
    end else begin
      idle_cnt = bump(idle_cnt);
      if (idle_cnt > cfg_gap && code_len != 0) begin
        ch = letter_of(code_len, code_pat);
        ev.kind = (ch != 0) ? EV_LETTER : EV_INVALID;
        ev.letter = ch;
        ev.len = code_len;
        ev.bits = code_pat;
        fired = 1'b1;
        if (ch != 0) idle_cnt = '0;
        code_pat = '0;
        code_len = '0;
      end else if (idle_cnt > cfg_inact) begin
        ev.kind = EV_INACTIVE;
        ev.len = code_len;
        ev.bits = code_pat;
        fired = 1'b1;
        code_pat = '0;
        code_len = '0;
        idle_cnt = '0;
      end
    end
  endtask

  // Offer one key word; on acceptance record what it should produce
  task automatic send_tick(input logic lvl, input logic typed, input logic t_fires,
                           input key_event_t t_ev);
    logic       fired;
    key_event_t ev;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {7'd0, lvl};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    decode_tick(lvl, fired, ev);
    if (typed) begin
      fired = t_fires;
      ev = t_ev;
    end
    if (fired) pending_events.push_back(ev);
    words_sent++;
  endtask

  task automatic tick(input logic lvl);
    send_tick(lvl, 1'b0, 1'b0, NO_EV);
  endtask

  // Stop sending, collect every outstanding event, let the pipeline empty
  task automatic wait_quiet();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DOT_LIMIT:  cfg_dot = val;
      REG_LETTER_GAP: cfg_gap = val;
      REG_INACTIVITY: cfg_inact = val;
      REG_DEBOUNCE:   cfg_deb = val[DEB_W-1:0];
      default: ;
    endcase
  endtask

  // A keyed letter: presses around the dot limit, noise during debounce, then a gap
  task automatic key_letter();
    int nsym;
    int width;
    int pause;
    nsym = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7);
    for (int s = 0; s < nsym; s++) begin
      if (cfg_dot > 1 && $urandom_range(0, 1) == 1) width = $urandom_range(1, cfg_dot - 1);
      else width = $urandom_range(cfg_dot, cfg_dot + 3);
      repeat (width) tick(1'b1);
      tick(1'b0);
      repeat (cfg_deb) tick(1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) tick(1'b0);
    end
    pause = cfg_gap + 1;
    if ($urandom_range(0, 3) == 0) pause += $urandom_range(0, cfg_inact);
    repeat (pause) tick(1'b0);
  endtask

  // Result checker
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected event, kind %0d data %h", $time, m_tuser_o, m_tdata_o);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, m_tuser_o);
        check_field("symbol", want.sym, m_tdata_o[0]);
        check_field("letter", want.letter, m_tdata_o[7:1]);
        check_field("code_length", want.len, m_tdata_o[10:8]);
        check_field("code_bits", want.bits, m_tdata_o[15:11]);
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t row;
    int          goal;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = script_rows[r];
      case (row.op)
        ROW_CFG: begin
          write_reg(row.arg[CFG_IDX_W-1:0], row.count[MS_W-1:0]);
        end
        ROW_LEVEL: begin
          for (int t = 0; t < row.count; t++) begin
            send_tick(row.arg[0], row.typed && t == row.count - 1, row.fires, row.ev);
          end
        end
        default: begin
          for (int p = 0; p < row.count; p++) begin
            repeat (row.arg) tick(1'b1);
            send_tick(1'b0, row.typed && p == row.count - 1, row.fires, row.ev);
          end
        end
      endcase
    end

    // random phases, each with fresh short timing and its own idling
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_DOT_LIMIT, MS_W'($urandom_range(1, 6)));
      write_reg(REG_LETTER_GAP, MS_W'($urandom_range(0, 12)));
      write_reg(REG_INACTIVITY, MS_W'($urandom_range(0, 30)));
      write_reg(REG_DEBOUNCE, MS_W'($urandom_range(0, 4)));
      sender_gap_pct = GAP_PCT[ph];
      stall_pct = STALL_PCT[ph];
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          key_letter();
        end else begin
          repeat ($urandom_range(1, 20)) tick(1'($urandom_range(0, 1)));
        end
      end
    end

    wait_quiet();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
